@@ design/nth_largest_first_index_select_macros.svh @@
// Assertion macros for the nth-largest first-index select block.
`ifndef NTH_LARGEST_FIRST_INDEX_SELECT_MACROS_SVH
`define NTH_LARGEST_FIRST_INDEX_SELECT_MACROS_SVH

`ifndef SYNTHESIS
`define NLFIS_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define NLFIS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NLFIS_CHECK(label, expr, msg)
`define NLFIS_CHECK_NEXT(label, ante, cons, msg)
`endif

`endif

@@ design/nlfis_pkg.sv @@
package nlfis_pkg;

    localparam int IDX_BITS  = 8;
    localparam int RANK_BITS = 8;

    typedef struct packed {
        logic ins;
        logic drain;
        logic clr;
    } nlfis_ctrl_t;

endpackage

@@ design/nlfis_ifs.sv @@
interface nlfis_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] rank;

    modport source (output valid, output rank, input ready);
    modport sink (input valid, input rank, output ready);
endinterface

interface nlfis_item_if #(
    parameter int MEASURE_BITS = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [MEASURE_BITS-1:0] measure;
    logic                           last;

    modport source (output valid, output measure, output last, input ready);
    modport sink (input valid, input measure, input last, output ready);
endinterface

interface nlfis_result_if #(
    parameter int MEASURE_BITS = 32
);
    logic                           valid;
    logic                           ready;
    logic [7:0]                     object_index;
    logic signed [MEASURE_BITS-1:0] selected_value;
    logic                           out_of_range;
    logic                           overflow;

    modport source (
        output valid, output object_index, output selected_value,
        output out_of_range, output overflow, input ready
    );
    modport sink (
        input valid, input object_index, input selected_value,
        input out_of_range, input overflow, output ready
    );
endinterface

@@ design/nth_largest_first_index_select.sv @@
// Nth-largest selection with first-index lookup.
// Channels: cfg writes the rank register (0 = largest); item carries one signed
// measure per transaction plus a last flag; result carries one transaction per
// set: the first arrival index holding the value at position rank, that value,
// an out-of-range flag and an overflow flag.
// Items are taken one per cycle while a set is being collected. Each enters a
// sorted insertion chain of MAX_ITEMS cells, descending, ties kept in arrival
// order; items beyond MAX_ITEMS are dropped and flagged.
// After the transaction with last set, the chain shifts toward its head once per
// cycle, rank times (not at all when the rank is out of range), and the head is
// then captured into the result register as soon as that register is free.
// Item ready is low from the last item until that capture.
// The result register holds its transaction while the receiver stalls; the next
// set may be collected meanwhile, and a second set closing stalls in its search
// until the result register frees up.
// Reset clears the set, the rank register and the result valid flag.
module nth_largest_first_index_select #(
    parameter int MAX_ITEMS    = 256,
    parameter int MEASURE_BITS = 32
) (
    input logic            clk,
    input logic            rst_n,
    nlfis_cfg_if.sink      cfg,
    nlfis_item_if.sink     item,
    nlfis_result_if.source result
);
    import nlfis_pkg::*;

    `include "nth_largest_first_index_select_macros.svh"

    localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
    localparam int CMP_BITS = (CNT_BITS > RANK_BITS) ? CNT_BITS : RANK_BITS;

    typedef enum logic {
        S_COLLECT,
        S_SEEK
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [CNT_BITS-1:0]            count_reg;
    logic [CNT_BITS-1:0]            count_next;
    logic                           drop_reg;
    logic                           drop_next;
    logic [RANK_BITS-1:0]           seek_reg;
    logic [RANK_BITS-1:0]           seek_next;
    logic                           oor_reg;
    logic                           oor_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [IDX_BITS-1:0]            out_idx_reg;
    logic [IDX_BITS-1:0]            out_idx_next;
    logic signed [MEASURE_BITS-1:0] out_val_reg;
    logic signed [MEASURE_BITS-1:0] out_val_next;
    logic                           out_oor_reg;
    logic                           out_oor_next;
    logic                           out_ovf_reg;
    logic                           out_ovf_next;
    logic [RANK_BITS-1:0]           rank_reg;

    logic                           item_acc;
    logic                           full;
    logic [CNT_BITS-1:0]            count_inc;
    logic                           oor_now;
    logic                           done;
    logic                           out_free;
    logic                           capture;
    logic [IDX_BITS-1:0]            arr_idx;
    nlfis_ctrl_t                    ctrl;

    logic                           ch_take  [MAX_ITEMS+1];
    logic                           ch_valid [MAX_ITEMS+2];
    logic signed [MEASURE_BITS-1:0] ch_val   [MAX_ITEMS+2];
    logic [IDX_BITS-1:0]            ch_grp   [MAX_ITEMS+2];

    assign item_acc  = item.valid && item.ready;
    assign full      = (count_reg == CNT_BITS'(MAX_ITEMS));
    assign count_inc = full ? count_reg : count_reg + 1'b1;
    assign oor_now   = (CMP_BITS'(rank_reg) >= CMP_BITS'(count_inc));
    assign done      = oor_reg || (seek_reg == '0);
    assign out_free  = !out_valid_reg || result.ready;
    assign capture   = (state_reg == S_SEEK) && done && out_free;
    assign arr_idx   = IDX_BITS'(count_reg);

    assign ctrl.ins   = item_acc && !full;
    assign ctrl.drain = (state_reg == S_SEEK) && !done;
    assign ctrl.clr   = capture;

    assign ch_take[0]            = 1'b0;
    assign ch_valid[0]           = 1'b0;
    assign ch_val[0]             = '0;
    assign ch_grp[0]             = '0;
    assign ch_valid[MAX_ITEMS+1] = 1'b0;
    assign ch_val[MAX_ITEMS+1]   = '0;
    assign ch_grp[MAX_ITEMS+1]   = '0;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        nlfis_cell #(
            .MEASURE_BITS(MEASURE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_val    (item.measure),
            .new_idx    (arr_idx),
            .prev_take  (ch_take[i]),
            .prev_valid (ch_valid[i]),
            .prev_val   (ch_val[i]),
            .prev_grp   (ch_grp[i]),
            .next_valid (ch_valid[i+2]),
            .next_val   (ch_val[i+2]),
            .next_grp   (ch_grp[i+2]),
            .take       (ch_take[i+1]),
            .valid      (ch_valid[i+1]),
            .val        (ch_val[i+1]),
            .grp        (ch_grp[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        seek_next      = seek_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_oor_next   = out_oor_reg;
        out_ovf_next   = out_ovf_reg;
        unique case (state_reg)
            S_COLLECT:
            begin
                if (item_acc)
                begin
                    count_next = count_inc;
                    drop_next  = drop_reg || full;
                    if (item.last)
                    begin
                        state_next = S_SEEK;
                        seek_next  = rank_reg;
                        oor_next   = oor_now;
                    end
                end
            end
            S_SEEK:
            begin
                if (capture)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = oor_reg ? '0 : ch_grp[1];
                    out_val_next   = oor_reg ? '0 : ch_val[1];
                    out_oor_next   = oor_reg;
                    out_ovf_next   = drop_reg;
                    count_next     = '0;
                    drop_next      = 1'b0;
                    state_next     = S_COLLECT;
                end
                else if (!done)
                begin
                    seek_next = seek_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            seek_reg      <= '0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_val_reg   <= '0;
            out_oor_reg   <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            seek_reg      <= seek_next;
            oor_reg       <= oor_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_val_reg   <= out_val_next;
            out_oor_reg   <= out_oor_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            rank_reg <= cfg.rank;
        end
    end

    assign cfg.ready             = 1'b1;
    assign item.ready            = (state_reg == S_COLLECT);
    assign result.valid          = out_valid_reg;
    assign result.object_index   = out_idx_reg;
    assign result.selected_value = out_val_reg;
    assign result.out_of_range   = out_oor_reg;
    assign result.overflow       = out_ovf_reg;

    `NLFIS_CHECK(a_count_bound, count_reg <= CNT_BITS'(MAX_ITEMS),
        "item count above capacity")
    `NLFIS_CHECK(a_oor_zero,
        !(out_valid_reg && out_oor_reg) || (out_idx_reg == '0 && out_val_reg == '0),
        "out-of-range result carries a payload")
    `NLFIS_CHECK(a_head_valid, !(state_reg == S_SEEK && !oor_reg) || ch_valid[1],
        "chain head empty during search")
    `NLFIS_CHECK_NEXT(a_capture_clears, capture,
        out_valid_reg && count_reg == '0 && !ch_valid[1],
        "capture did not clear the set")

endmodule

@@ design/nlfis_cell.sv @@
module nlfis_cell #(
    parameter int MEASURE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nlfis_pkg::nlfis_ctrl_t         ctrl,
    input  logic signed [MEASURE_BITS-1:0] new_val,
    input  logic [nlfis_pkg::IDX_BITS-1:0] new_idx,
    input  logic                           prev_take,
    input  logic                           prev_valid,
    input  logic signed [MEASURE_BITS-1:0] prev_val,
    input  logic [nlfis_pkg::IDX_BITS-1:0] prev_grp,
    input  logic                           next_valid,
    input  logic signed [MEASURE_BITS-1:0] next_val,
    input  logic [nlfis_pkg::IDX_BITS-1:0] next_grp,
    output logic                           take,
    output logic                           valid,
    output logic signed [MEASURE_BITS-1:0] val,
    output logic [nlfis_pkg::IDX_BITS-1:0] grp
);
    import nlfis_pkg::*;

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [MEASURE_BITS-1:0] val_reg;
    logic signed [MEASURE_BITS-1:0] val_next;
    logic [IDX_BITS-1:0]            grp_reg;
    logic [IDX_BITS-1:0]            grp_next;
    logic                           tie;

    assign take = !valid_reg || (new_val > val_reg);
    assign tie  = prev_valid && (prev_val == new_val);

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        grp_next   = grp_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.drain)
        begin
            valid_next = next_valid;
            val_next   = next_val;
            grp_next   = next_grp;
        end
        else if (ctrl.ins && take)
        begin
            if (prev_take)
            begin
                valid_next = prev_valid;
                val_next   = prev_val;
                grp_next   = prev_grp;
            end
            else
            begin
                valid_next = 1'b1;
                val_next   = new_val;
                grp_next   = tie ? prev_grp : new_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        grp_reg <= grp_next;
    end

    assign valid = valid_reg;
    assign val   = val_reg;
    assign grp   = grp_reg;

endmodule
